@@ src/mfd_pkg.sv @@
// shared types, constants and the crc-16 byte update for the modbus frame deframer
// no dependencies; imported by every module of the block
`default_nettype none

package mfd_pkg;

    // defaults for the top-level parameters
    localparam int BUFFER_DEPTH_DEF  = 512;
    localparam int COUNTER_WIDTH_DEF = 32;

    // buffer offsets reach at most 6 + 255 + 1
    localparam int OFF_W     = 9;
    localparam int OUT_CNT_W = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND_B = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RST    = 8'h01;
    localparam logic [7:0] SYNC_SECOND_A_RST = 8'h64;
    localparam logic [7:0] SYNC_SECOND_B_RST = 8'h65;

    // frame layout
    localparam int HDR_FRAME_LEN = 7;   // bare header incl. crc
    localparam int HDR_CRC_LEN   = 5;   // bytes covered by the header crc
    localparam int HDR_FIELDS    = 6;   // reported header bytes
    localparam int LEN_OFFSET    = 5;   // position of the length byte
    localparam int CRC_HI_OFFSET = 6;   // high crc byte of a bare header
    localparam int CRC_BYTES     = 2;

    // result status codes
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_HDR_DISC = 2'd1;
    localparam logic [1:0] ST_FRAME_OK = 2'd2;
    localparam logic [1:0] ST_CRC_FAIL = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // commands from the sequencer to the ring buffer
    typedef struct packed {
        logic             push;
        logic             discard;
        logic [OFF_W-1:0] discard_n;
    } t_ring_cmd;

    // one byte of the reflected modbus crc-16
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/mfd_crc_unit.sv @@
// shared crc-16 accumulator, one byte per enabled cycle
// depends on mfd_pkg for the byte update function
`default_nettype none

module mfd_crc_unit (
    input  wire logic        i_clk,
    input  wire logic        i_init,
    input  wire logic        i_en,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);
    import mfd_pkg::*;

    logic [15:0] r_crc;

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_crc <= CRC_INIT;
        end else if (i_en) begin
            r_crc <= crc16_update(r_crc, i_byte);
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

@@ src/mfd_ring_buf.sv @@
// byte ring buffer: storage, read pointer and fill level
// depends on mfd_pkg for the command struct and offset width
`default_nettype none

module mfd_ring_buf #(
    parameter  int DEPTH = mfd_pkg::BUFFER_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH),
    localparam int FW    = $clog2(DEPTH + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire mfd_pkg::t_ring_cmd      i_cmd,
    input  wire logic [7:0]              i_wr_data,
    input  wire logic [mfd_pkg::OFF_W-1:0] i_rd_off,
    output logic      [7:0]              o_rd_data,
    output logic      [FW-1:0]           o_fill,
    output logic                         o_full
);
    import mfd_pkg::*;

    localparam int SW = ((AW > OFF_W) ? AW : OFF_W) + 1;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_rp, n_rp;
    logic [FW-1:0] r_fill, n_fill;
    logic [SW-1:0] w_wsum, w_rsum, w_dsum, w_isum;
    logic [AW-1:0] w_waddr, w_raddr;

    assign o_full = (r_fill == FW'(DEPTH));

    always_comb begin
        // every sum stays below twice the depth, one subtract wraps it
        w_wsum = SW'(r_rp) + SW'(r_fill);
        if (w_wsum >= SW'(DEPTH)) begin
            w_wsum = w_wsum - SW'(DEPTH);
        end
        w_rsum = SW'(r_rp) + SW'(i_rd_off);
        if (w_rsum >= SW'(DEPTH)) begin
            w_rsum = w_rsum - SW'(DEPTH);
        end
        w_dsum = SW'(r_rp) + SW'(i_cmd.discard_n);
        if (w_dsum >= SW'(DEPTH)) begin
            w_dsum = w_dsum - SW'(DEPTH);
        end
        w_isum = SW'(r_rp) + SW'(1);
        if (w_isum >= SW'(DEPTH)) begin
            w_isum = w_isum - SW'(DEPTH);
        end
        w_waddr = AW'(w_wsum);
        w_raddr = AW'(w_rsum);
    end

    always_comb begin
        n_rp   = r_rp;
        n_fill = r_fill;
        if (i_cmd.push) begin
            if (o_full) begin
                // oldest byte goes, new one lands in its slot
                n_rp = AW'(w_isum);
            end else begin
                n_fill = r_fill + FW'(1);
            end
        end else if (i_cmd.discard) begin
            n_rp   = AW'(w_dsum);
            n_fill = r_fill - FW'(i_cmd.discard_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[w_waddr] <= i_wr_data;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    assign o_rd_data = r_rd_data;
    assign o_fill    = r_fill;

endmodule

`default_nettype wire

@@ src/modbus_frame_deframer.sv @@
// modbus rtu deframer top level: sequencer, counters, config and result register
// depends on mfd_pkg, mfd_ring_buf and mfd_crc_unit
// a beat first walks and evaluates the header; when a frame is checked the crc unit then
//   walks the whole frame byte by byte, and only then is the result register loaded
// no new beat is taken until the result is loaded; a held result stalls input
// reset: synchronous active-low clears pointers, fill, counters, config and state
`default_nettype none

module modbus_frame_deframer #(
    parameter int BUFFER_DEPTH  = mfd_pkg::BUFFER_DEPTH_DEF,
    parameter int COUNTER_WIDTH = mfd_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [mfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    // input byte channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [7:0]                      i_rx_byte,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [1:0]                      o_status,
    output logic                                 o_byte_dropped,
    output logic      [7:0]                      o_slave_address,
    output logic      [7:0]                      o_function_code,
    output logic      [7:0]                      o_param_one,
    output logic      [7:0]                      o_param_two,
    output logic      [7:0]                      o_sub_function,
    output logic      [7:0]                      o_payload_length,
    output logic      [mfd_pkg::OUT_CNT_W-1:0]   o_dropped_total,
    output logic      [mfd_pkg::OUT_CNT_W-1:0]   o_crc_fail_total,
    output logic      [mfd_pkg::OUT_CNT_W-1:0]   o_frame_total
);
    import mfd_pkg::*;

    localparam int FW    = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W = (FW > OFF_W) ? FW : OFF_W;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK1 = 6'b000010,   // read bytes 0..6, crc over 0..4
        S_EVAL1 = 6'b000100,   // sync, bare header and length decisions
        S_WALK2 = 6'b001000,   // continue crc over 5..body-1, fetch trailing crc
        S_EVAL2 = 6'b010000,   // frame crc verdict
        S_OUT   = 6'b100000    // hand result to the output register
    } t_state;

    t_state r_state, n_state;

    // config
    logic [7:0] r_sync_first, r_sync_second_a, r_sync_second_b;

    // walk control
    logic [OFF_W-1:0] r_off, r_last, r_doff, r_body;
    logic             r_issue, r_dv;

    // captured bytes and verdict
    logic [7:0]  r_hdr [HDR_FIELDS];
    logic [15:0] r_exp;
    logic [1:0]  r_status;
    logic        r_dropped;

    // saturating counters
    logic [COUNTER_WIDTH-1:0] r_drop_cnt, r_fail_cnt, r_good_cnt;

    // result register
    logic                 r_out_valid;
    logic [1:0]           r_o_status;
    logic                 r_o_dropped;
    logic [7:0]           r_o_hdr [HDR_FIELDS];
    logic [OUT_CNT_W-1:0] r_o_drop_cnt, r_o_fail_cnt, r_o_good_cnt;

    // ring buffer and crc unit hookup
    t_ring_cmd   w_cmd;
    logic [7:0]  w_rd_data;
    logic [FW-1:0] w_fill;
    logic        w_full;
    logic        w_crc_init, w_crc_en;
    logic [15:0] w_crc;

    logic             w_accept, w_walking, w_walk_done, w_load;
    logic             w_sync_ok, w_enough_hdr, w_enough_frame;
    logic [OFF_W-1:0] w_body1, w_need1, w_need2;
    logic [CMP_W-1:0] w_fill_ext;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_walking  = (r_state == S_WALK1) || (r_state == S_WALK2);
    assign w_walk_done = !r_issue && !r_dv;
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign w_fill_ext = CMP_W'(w_fill);
    assign w_body1    = OFF_W'(r_hdr[LEN_OFFSET]) + OFF_W'(HDR_FIELDS);
    assign w_need1    = w_body1 + OFF_W'(CRC_BYTES);
    assign w_need2    = r_body + OFF_W'(CRC_BYTES);

    assign w_sync_ok = (r_hdr[0] == r_sync_first) &&
                       ((r_hdr[1] == r_sync_second_a) || (r_hdr[1] == r_sync_second_b));
    assign w_enough_hdr   = w_fill_ext >= CMP_W'(HDR_FRAME_LEN);
    assign w_enough_frame = w_fill_ext >= CMP_W'(w_need1);

    // crc starts fresh with each beat, walk 1 feeds only the header crc bytes
    assign w_crc_init = w_accept;
    assign w_crc_en   = r_dv && (((r_state == S_WALK1) && (r_doff < OFF_W'(HDR_CRC_LEN))) ||
                                 ((r_state == S_WALK2) && (r_doff < r_body)));

    always_comb begin
        w_cmd.push      = w_accept;
        w_cmd.discard   = 1'b0;
        w_cmd.discard_n = '0;
        if ((r_state == S_EVAL1) && w_enough_hdr && w_sync_ok && (w_crc == r_exp)) begin
            // bare header
            w_cmd.discard   = 1'b1;
            w_cmd.discard_n = OFF_W'(HDR_FRAME_LEN);
        end else if (r_state == S_EVAL2) begin
            w_cmd.discard   = 1'b1;
            w_cmd.discard_n = w_need2;
        end
    end

    mfd_ring_buf #(
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_wr_data (i_rx_byte),
        .i_rd_off  (r_off),
        .o_rd_data (w_rd_data),
        .o_fill    (w_fill),
        .o_full    (w_full)
    );

    mfd_crc_unit u_crc (
        .i_clk  (i_clk),
        .i_init (w_crc_init),
        .i_en   (w_crc_en),
        .i_byte (w_rd_data),
        .o_crc  (w_crc)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_WALK1;
                end
            end
            S_WALK1: begin
                if (w_walk_done) begin
                    n_state = S_EVAL1;
                end
            end
            S_EVAL1: begin
                if (w_enough_hdr && w_sync_ok && (w_crc != r_exp) && w_enough_frame) begin
                    n_state = S_WALK2;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WALK2: begin
                if (w_walk_done) begin
                    n_state = S_EVAL2;
                end
            end
            S_EVAL2: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_sync_first     <= SYNC_FIRST_RST;
            r_sync_second_a  <= SYNC_SECOND_A_RST;
            r_sync_second_b  <= SYNC_SECOND_B_RST;
            r_issue          <= 1'b0;
            r_dv             <= 1'b0;
            r_off            <= '0;
            r_last           <= '0;
            r_doff           <= '0;
            r_body           <= '0;
            r_status         <= ST_NONE;
            r_dropped        <= 1'b0;
            r_drop_cnt       <= '0;
            r_fail_cnt       <= '0;
            r_good_cnt       <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SYNC_FIRST:    r_sync_first    <= i_cfg_data;
                    CFG_SYNC_SECOND_A: r_sync_second_a <= i_cfg_data;
                    CFG_SYNC_SECOND_B: r_sync_second_b <= i_cfg_data;
                    default: ;
                endcase
            end

            // read pipeline: address issued now, data in the next cycle
            r_dv   <= w_walking && r_issue;
            r_doff <= r_off;
            if (w_walking && r_issue) begin
                r_off <= r_off + OFF_W'(1);
                if (r_off == r_last) begin
                    r_issue <= 1'b0;
                end
            end

            if (w_accept) begin
                r_off     <= '0;
                r_last    <= OFF_W'(HDR_FRAME_LEN - 1);
                r_issue   <= 1'b1;
                r_status  <= ST_NONE;
                r_dropped <= w_full;
                if (w_full && (r_drop_cnt != '1)) begin
                    r_drop_cnt <= r_drop_cnt + COUNTER_WIDTH'(1);
                end
            end

            if ((r_state == S_EVAL1) && w_enough_hdr && w_sync_ok) begin
                if (w_crc == r_exp) begin
                    r_status <= ST_HDR_DISC;
                end else if (w_enough_frame) begin
                    // carry on from the length byte with the crc so far
                    r_off   <= OFF_W'(LEN_OFFSET);
                    r_last  <= w_need1 - OFF_W'(1);
                    r_body  <= w_body1;
                    r_issue <= 1'b1;
                end
            end

            if (r_state == S_EVAL2) begin
                if (w_crc == r_exp) begin
                    r_status <= ST_FRAME_OK;
                    if (r_good_cnt != '1) begin
                        r_good_cnt <= r_good_cnt + COUNTER_WIDTH'(1);
                    end
                end else begin
                    r_status <= ST_CRC_FAIL;
                    if (r_fail_cnt != '1) begin
                        r_fail_cnt <= r_fail_cnt + COUNTER_WIDTH'(1);
                    end
                end
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_dv && (r_state == S_WALK1)) begin
            if (r_doff < OFF_W'(HDR_FIELDS)) begin
                r_hdr[r_doff[2:0]] <= w_rd_data;
            end
            if (r_doff == OFF_W'(LEN_OFFSET)) begin
                r_exp[7:0] <= w_rd_data;
            end
            if (r_doff == OFF_W'(CRC_HI_OFFSET)) begin
                r_exp[15:8] <= w_rd_data;
            end
        end
        if (r_dv && (r_state == S_WALK2)) begin
            if (r_doff == r_body) begin
                r_exp[7:0] <= w_rd_data;
            end
            if (r_doff == (r_body + OFF_W'(1))) begin
                r_exp[15:8] <= w_rd_data;
            end
        end

        if (w_load) begin
            r_o_status   <= r_status;
            r_o_dropped  <= r_dropped;
            for (int k = 0; k < HDR_FIELDS; k++) begin
                // header fields read as zero unless a good frame was found
                r_o_hdr[k] <= (r_status == ST_FRAME_OK) ? r_hdr[k] : 8'h00;
            end
            r_o_drop_cnt <= OUT_CNT_W'(r_drop_cnt);
            r_o_fail_cnt <= OUT_CNT_W'(r_fail_cnt);
            r_o_good_cnt <= OUT_CNT_W'(r_good_cnt);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_byte_dropped   = r_o_dropped;
    assign o_slave_address  = r_o_hdr[0];
    assign o_function_code  = r_o_hdr[1];
    assign o_param_one      = r_o_hdr[2];
    assign o_param_two      = r_o_hdr[3];
    assign o_sub_function   = r_o_hdr[4];
    assign o_payload_length = r_o_hdr[5];
    assign o_dropped_total  = r_o_drop_cnt;
    assign o_crc_fail_total = r_o_fail_cnt;
    assign o_frame_total    = r_o_good_cnt;

    // one beat at a time: taking a beat closes the input until the result is handed on
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again straight after a beat");

    // fill level never passes the buffer depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill_ext <= CMP_W'(BUFFER_DEPTH))
        else $error("ring fill above depth");

    // a frame verdict only happens with the whole frame buffered
    a_frame_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL2) |-> (w_fill_ext >= CMP_W'(w_need2)))
        else $error("frame removed before fully buffered");

endmodule

`default_nettype wire

@@ tb/mfd_checker.sv @@
// result checker for the modbus frame deframer: follows the byte, config and result channels
// keeps its own copy of the ring buffer and counters and compares every result beat
// depends on mfd_pkg for the status codes, register indexes and frame layout
`timescale 1ns / 100ps

module mfd_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [mfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic [7:0]                     i_rx_byte,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [1:0]                     i_status,
    input  wire logic                           i_byte_dropped,
    input  wire logic [7:0]                     i_slave_address,
    input  wire logic [7:0]                     i_function_code,
    input  wire logic [7:0]                     i_param_one,
    input  wire logic [7:0]                     i_param_two,
    input  wire logic [7:0]                     i_sub_function,
    input  wire logic [7:0]                     i_payload_length,
    input  wire logic [mfd_pkg::OUT_CNT_W-1:0]  i_dropped_total,
    input  wire logic [mfd_pkg::OUT_CNT_W-1:0]  i_crc_fail_total,
    input  wire logic [mfd_pkg::OUT_CNT_W-1:0]  i_frame_total,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import mfd_pkg::*;

    localparam int unsigned DEPTH = BUFFER_DEPTH_DEF;
    localparam int          AW    = $clog2(DEPTH);

    typedef struct packed {
        logic [1:0]           status;
        logic                 dropped;
        logic [7:0]           slave_address;
        logic [7:0]           function_code;
        logic [7:0]           param_one;
        logic [7:0]           param_two;
        logic [7:0]           sub_function;
        logic [7:0]           payload_length;
        logic [OUT_CNT_W-1:0] dropped_total;
        logic [OUT_CNT_W-1:0] crc_fail_total;
        logic [OUT_CNT_W-1:0] frame_total;
    } t_deframe_result;

    logic [7:0]           ring [DEPTH];
    int unsigned          rd_ptr;
    int unsigned          fill;
    logic [OUT_CNT_W-1:0] drop_cnt;
    logic [OUT_CNT_W-1:0] bad_crc_cnt;
    logic [OUT_CNT_W-1:0] good_cnt;
    logic [7:0]           sync_first;
    logic [7:0]           sync_second_a;
    logic [7:0]           sync_second_b;
    t_deframe_result      expected_q [$];
    int                   fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic logic [7:0] buffered(input int unsigned offset);
        return ring[AW'((rd_ptr + offset) % DEPTH)];
    endfunction

    function automatic void drop_front(input int unsigned n);
        int unsigned k;
        k = (n > fill) ? fill : n;
        rd_ptr = (rd_ptr + k) % DEPTH;
        fill   = fill - k;
    endfunction

    function automatic logic [OUT_CNT_W-1:0] sat_inc(input logic [OUT_CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // reflected crc-16 over the first n buffered bytes
    function automatic logic [15:0] front_crc(input int unsigned n);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int unsigned i = 0; i < n; i++) begin
            crc = crc ^ {8'h00, buffered(i)};
            repeat (8) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    // one accepted rx beat: append, try to pull a header or frame off the front
    task automatic predict_beat(input logic [7:0] rx);
        t_deframe_result r;
        logic [15:0]     crc_rx;
        int unsigned     span;
        r = '0;
        r.status = ST_NONE;
        if (fill >= DEPTH) begin
            drop_front(1);
            drop_cnt  = sat_inc(drop_cnt);
            r.dropped = 1'b1;
        end
        ring[AW'((rd_ptr + fill) % DEPTH)] = rx;
        fill++;
        if (fill >= HDR_FRAME_LEN && buffered(0) == sync_first &&
            (buffered(1) == sync_second_a || buffered(1) == sync_second_b)) begin
            crc_rx = {buffered(CRC_HI_OFFSET), buffered(LEN_OFFSET)};
            if (front_crc(HDR_CRC_LEN) == crc_rx) begin
                drop_front(HDR_FRAME_LEN);
                r.status = ST_HDR_DISC;
            end else begin
                span = HDR_FIELDS + buffered(LEN_OFFSET);
                if (fill >= span + CRC_BYTES) begin
                    crc_rx = {buffered(span + 1), buffered(span)};
                    if (front_crc(span) == crc_rx) begin
                        r.slave_address  = buffered(0);
                        r.function_code  = buffered(1);
                        r.param_one      = buffered(2);
                        r.param_two      = buffered(3);
                        r.sub_function   = buffered(4);
                        r.payload_length = buffered(5);
                        good_cnt = sat_inc(good_cnt);
                        r.status = ST_FRAME_OK;
                    end else begin
                        bad_crc_cnt = sat_inc(bad_crc_cnt);
                        r.status    = ST_CRC_FAIL;
                    end
                    drop_front(span + CRC_BYTES);
                end
            end
        end
        r.dropped_total  = drop_cnt;
        r.crc_fail_total = bad_crc_cnt;
        r.frame_total    = good_cnt;
        expected_q.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    task automatic check_result();
        t_deframe_result e;
        if (expected_q.size() == 0) begin
            $error("result beat with no rx beat waiting for it");
            fails++;
        end else begin
            e = expected_q.pop_front();
            check_field("status", 32'(e.status), 32'(i_status));
            check_field("byte_dropped", 32'(e.dropped), 32'(i_byte_dropped));
            check_field("slave_address", 32'(e.slave_address), 32'(i_slave_address));
            check_field("function_code", 32'(e.function_code), 32'(i_function_code));
            check_field("param_one", 32'(e.param_one), 32'(i_param_one));
            check_field("param_two", 32'(e.param_two), 32'(i_param_two));
            check_field("sub_function", 32'(e.sub_function), 32'(i_sub_function));
            check_field("payload_length", 32'(e.payload_length), 32'(i_payload_length));
            check_field("dropped_total", 32'(e.dropped_total), 32'(i_dropped_total));
            check_field("crc_fail_total", 32'(e.crc_fail_total), 32'(i_crc_fail_total));
            check_field("frame_total", 32'(e.frame_total), 32'(i_frame_total));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_ptr        = 0;
            fill          = 0;
            drop_cnt      = '0;
            bad_crc_cnt   = '0;
            good_cnt      = '0;
            sync_first    = SYNC_FIRST_RST;
            sync_second_a = SYNC_SECOND_A_RST;
            sync_second_b = SYNC_SECOND_B_RST;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SYNC_FIRST:    sync_first    = i_cfg_data;
                    CFG_SYNC_SECOND_A: sync_second_a = i_cfg_data;
                    CFG_SYNC_SECOND_B: sync_second_b = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_beat(i_rx_byte);
            end
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
// top of the modbus frame deframer testbench: clock, reset, config, byte stimulus and verdict
// depends on mfd_pkg, modbus_frame_deframer and mfd_checker
`timescale 1ns / 100ps

module testbench;
    import mfd_pkg::*;

    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int IDLE_SETTLE   = 16;     // quiet cycles after the last result
    localparam int FINAL_SETTLE  = 300;    // longest frame check plus margin
    localparam int NUM_PHASES    = 5;

    typedef logic [7:0] t_byte_q [$];
    typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_BARE_HEADER} t_frame_kind;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SYNC_FIRST;
    logic [7:0]           i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_rx_byte   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_status;
    logic                 o_byte_dropped;
    logic [7:0]           o_slave_address;
    logic [7:0]           o_function_code;
    logic [7:0]           o_param_one;
    logic [7:0]           o_param_two;
    logic [7:0]           o_sub_function;
    logic [7:0]           o_payload_length;
    logic [OUT_CNT_W-1:0] o_dropped_total;
    logic [OUT_CNT_W-1:0] o_crc_fail_total;
    logic [OUT_CNT_W-1:0] o_frame_total;

    int          fail_count;
    int          beats_pending;
    logic        no_idle    = 1'b0;   // both sides run flat out while set, apart from the long receiver hold-offs
    int unsigned bytes_sent = 0;

    // sync pair as currently programmed, used to build frames
    logic [7:0] sync_first_now    = SYNC_FIRST_RST;
    logic [7:0] sync_second_a_now = SYNC_SECOND_A_RST;
    logic [7:0] sync_second_b_now = SYNC_SECOND_B_RST;

    always #1 i_clk = ~i_clk;

    modbus_frame_deframer uut (.*);

    mfd_checker frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (o_status),
        .i_byte_dropped   (o_byte_dropped),
        .i_slave_address  (o_slave_address),
        .i_function_code  (o_function_code),
        .i_param_one      (o_param_one),
        .i_param_two      (o_param_two),
        .i_sub_function   (o_sub_function),
        .i_payload_length (o_payload_length),
        .i_dropped_total  (o_dropped_total),
        .i_crc_fail_total (o_crc_fail_total),
        .i_frame_total    (o_frame_total),
        .o_fail_count     (fail_count),
        .o_pending        (beats_pending)
    );

    // modbus crc-16 over a whole byte queue, for building frames
    function automatic logic [15:0] modbus_crc(input t_byte_q data);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (data[i]) begin
            crc = crc ^ {8'h00, data[i]};
            for (int b = 0; b < 8; b++) begin
                if (crc[0]) begin
                    crc = (crc >> 1) ^ CRC_POLY;
                end else begin
                    crc = crc >> 1;
                end
            end
        end
        return crc;
    endfunction

    // five leading bytes: sync pair then three random header bytes
    function automatic t_byte_q random_head();
        t_byte_q h;
        h.push_back(sync_first_now);
        h.push_back($urandom_range(1) ? sync_second_a_now : sync_second_b_now);
        repeat (3) h.push_back(8'($urandom_range(255)));
        return h;
    endfunction

    // one rx beat; the gap goes before valid is raised, never while it is up
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = (!no_idle && $urandom_range(99) < 35) ? $urandom_range(30, 1) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= value;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    // head holds the first five bytes; length byte, payload and crc are appended here (only the crc for a bare header)
    task automatic send_frame(input t_frame_kind kind, input t_byte_q head,
                              input int unsigned len);
        t_byte_q     q;
        logic [15:0] crc;
        q = head;
        if (kind != FRAME_BARE_HEADER) begin
            q.push_back(8'(len));
            repeat (len) q.push_back(8'($urandom_range(255)));
        end
        crc = modbus_crc(q);
        if (kind == FRAME_BAD_CRC) begin
            crc = crc ^ 16'($urandom_range(16'hFFFF, 1));
        end
        q.push_back(crc[7:0]);
        q.push_back(crc[15:8]);
        foreach (q[i]) send_byte(q[i]);
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        int unsigned len;
        t_frame_kind kind;
        pick = $urandom_range(99);
        kind = (pick < 60) ? FRAME_GOOD : (pick < 80) ? FRAME_BAD_CRC : FRAME_BARE_HEADER;
        // mostly short payloads, now and then up to the full length range
        len  = ($urandom_range(99) < 2) ? $urandom_range(255) : $urandom_range(12);
        send_frame(kind, random_head(), len);
    endtask

    // drop valid and wait for every outstanding result, then let the block settle
    task automatic drain_results(input int settle);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (beats_pending != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // all three registers back to back, only while the block is idle
    task automatic configure(input logic [7:0] first, input logic [7:0] second_a,
                             input logic [7:0] second_b);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_SYNC_FIRST;
        i_cfg_data  <= first;
        @(posedge i_clk);
        i_cfg_index <= CFG_SYNC_SECOND_A;
        i_cfg_data  <= second_a;
        @(posedge i_clk);
        i_cfg_index <= CFG_SYNC_SECOND_B;
        i_cfg_data  <= second_b;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sync_first_now    = first;
        sync_second_a_now = second_a;
        sync_second_b_now = second_b;
    endtask

    // result side: random back-pressure plus two long hold-offs that stall the input
    initial begin
        int unsigned results_taken;
        int unsigned next_hold;
        results_taken = 0;
        next_hold     = 150;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                results_taken++;
            end
            if (results_taken >= next_hold) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                next_hold += 850;
            end
            i_out_ready <= no_idle || ($urandom_range(99) >= 35);
        end
    end

    initial begin
        int unsigned budget;
        int unsigned phase_end;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bare header, good frame on the second sync value, bad crc
        // header bytes cover the all-zero and all-one extremes
        send_frame(FRAME_BARE_HEADER,
                   '{SYNC_FIRST_RST, SYNC_SECOND_A_RST, 8'h00, 8'hFF, 8'h80}, 0);
        send_frame(FRAME_GOOD,
                   '{SYNC_FIRST_RST, SYNC_SECOND_B_RST, 8'hFF, 8'h00, 8'h7F}, 1);
        send_frame(FRAME_BAD_CRC,
                   '{SYNC_FIRST_RST, SYNC_SECOND_A_RST, 8'h00, 8'h00, 8'h00}, 0);
        drain_results(IDLE_SETTLE);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: budget = 300;
                1: begin
                    budget = 300;
                    configure(8'h00, 8'hFF, 8'h00);
                end
                2: begin
                    budget = 650;
                    configure(8'hFF, 8'h00, 8'hFF);
                end
                3: begin
                    budget = 200;
                    configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                end
                default: begin
                    budget = 176;
                    configure(SYNC_FIRST_RST, SYNC_SECOND_B_RST, SYNC_SECOND_A_RST);
                end
            endcase
            no_idle   = (phase == 1);
            phase_end = bytes_sent + budget;

            // longest possible frame
            if (phase == 1) begin
                send_frame(FRAME_GOOD, random_head(), 255);
            end
            // junk at the front: nothing is removed until the buffer overflows
            // and the junk has been pushed out one byte at a time
            if (phase == 2) begin
                send_byte(sync_first_now ^ 8'h5A);
                repeat (7) send_byte(8'($urandom_range(255)));
            end

            while (bytes_sent < phase_end) begin
                send_random_frame();
            end
            drain_results(IDLE_SETTLE);
        end

        no_idle = 1'b0;
        drain_results(FINAL_SETTLE);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ modbus_frame_deframer.f @@
src/mfd_pkg.sv
src/mfd_crc_unit.sv
src/mfd_ring_buf.sv
src/modbus_frame_deframer.sv
tb/mfd_checker.sv
tb/testbench.sv
